>>> rtl/cuckoo_filter_engine_unit_assert.svh
// assertion macros used by the checker file
`ifndef CUCKOO_FILTER_ENGINE_UNIT_ASSERT_SVH
`define CUCKOO_FILTER_ENGINE_UNIT_ASSERT_SVH

// same-cycle implication, held off during reset
`define CFE_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, held off during reset
`define CFE_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/cfe_pkg.sv
// shared constants, types and helper functions of the cuckoo filter engine
package cfe_pkg;

	localparam int BUCKETS  = 4096;
	localparam int BKT_W    = 12;
	localparam int NESTS    = 4;
	localparam int NEST_W   = 2;
	localparam int FP_W     = 16;
	localparam int ROW_W    = NESTS * FP_W;
	localparam int KEY_W    = 64;
	localparam int CNT_W    = 15;
	localparam int KICK_W   = 10;
	localparam int SEED_W   = 32;
	localparam int LOG_W    = 4;
	localparam int MODE_W   = 2;
	localparam int STAT_W   = 2;
	localparam int SALT_W   = 10;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W    = 32;
	localparam int OUT_W    = 40;
	localparam int QDEPTH   = 2;
	localparam int Q_PTR_W  = 1;
	localparam int Q_CNT_W  = 2;

	// request modes
	localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd0;
	localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
	localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

	// result status codes
	localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
	localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_LOG   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KICKS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SEED  = 2'd2;

	localparam logic [SALT_W-1:0] FP_SALT  = 10'd1000;
	localparam logic [SALT_W-1:0] ALT_SALT = 10'd900;

	// murmur3 x86_32 constants
	localparam logic [31:0] MM_C1 = 32'hcc9e2d51;
	localparam logic [31:0] MM_C2 = 32'h1b873593;
	localparam logic [31:0] MM_E  = 32'he6546b64;
	localparam logic [31:0] MM_F1 = 32'h85ebca6b;
	localparam logic [31:0] MM_F2 = 32'hc2b2ae35;

	localparam logic [31:0] LFSR_TAPS = 32'h80200003;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [FP_W-1:0]   fp;
		logic [BKT_W-1:0]  h1;
		logic [BKT_W-1:0]  h2;
	} req_t;

	typedef struct packed {
		logic              start;
		logic              len8;
		logic [SEED_W-1:0] seed;
		logic [KEY_W-1:0]  data;
	} hash_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] value;
	} hash_rsp_t;

	// bucket index mask, saturated at the table size
	function automatic logic [BKT_W-1:0] bkt_mask(input logic [LOG_W-1:0] lg);
		logic [BKT_W:0] one_hot;
		one_hot = (BKT_W+1)'(1) << lg;
		if (lg >= LOG_W'(BKT_W))
			return '1;
		return BKT_W'(one_hot - 1'b1);
	endfunction

	// (a + n*b) mod bucket count, only the low bits matter
	function automatic logic [BKT_W-1:0] salt_mod(input logic [BKT_W-1:0] a,
		input logic [BKT_W-1:0] b, input logic [SALT_W-1:0] n,
		input logic [BKT_W-1:0] mask);
		logic [BKT_W-1:0] p;
		p = b * BKT_W'(n);
		return (a + p) & mask;
	endfunction

	// one galois lfsr step
	function automatic logic [31:0] lfsr_next(input logic [31:0] x);
		logic [31:0] r;
		r = x >> 1;
		if (x[0])
			r = r ^ LFSR_TAPS;
		return r;
	endfunction

endpackage

>>> rtl/cuckoo_filter_engine_unit.sv
// Cuckoo filter engine with 4096 buckets of four 16-bit fingerprints. After
// reset the bucket memory is cleared one row a cycle, so no request is taken
// until the clear is done. The front hashes each key with four murmur3
// passes: two over the 8-byte key and two over the 4-byte fingerprint. It
// takes no new request until the current one is pushed into the queue. The
// back then reads the two candidate rows one after the other through its
// single read port for a lookup, remove or plain insert. Each eviction adds a
// swap write, two hash passes for the displaced fingerprint's alternate bucket
// and the reads of both its candidate rows. A two-entry queue lets the front
// hash the next request while the back works or the result waits.
module cuckoo_filter_engine_unit import cfe_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [KEY_W-1:0]     s_tdata,    // key[63:0]
	input  logic [MODE_W-1:0]    s_tuser,    // mode[1:0]
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [OUT_W-1:0]     m_tdata,    // status[1:0], fingerprint[17:2],
	                                         // stored_total[32:18], victim_held[33]
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata
);

	logic [LOG_W-1:0]  log_q;
	logic [KICK_W-1:0] kicks_q;
	logic [SEED_W-1:0] seed_q;
	logic [BKT_W-1:0]  mask;
	logic              back_ready, q_push, q_full, q_pop, q_empty;
	req_t              q_wdata, q_head;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			log_q   <= LOG_W'(12);
			kicks_q <= KICK_W'(100);
			seed_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LOG:   log_q   <= cfg_wdata[LOG_W-1:0];
				REG_KICKS: kicks_q <= cfg_wdata[KICK_W-1:0];
				REG_SEED:  seed_q  <= cfg_wdata[SEED_W-1:0];
				default: ;
			endcase
		end
	end

	assign mask = bkt_mask(log_q);

	cfe_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.enable   (back_ready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.seed     (seed_q),
		.mask     (mask),
		.q_push   (q_push),
		.q_data   (q_wdata),
		.q_full   (q_full)
	);

	cfe_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (q_head),
		.empty  (q_empty)
	);

	cfe_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.ready     (back_ready),
		.q_empty   (q_empty),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.max_kicks (kicks_q),
		.seed      (seed_q),
		.mask      (mask),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

>>> rtl/cfe_murmur.sv
// multi-cycle murmur3 x86_32 unit for 4- or 8-byte data, one multiply per cycle
module cfe_murmur import cfe_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  hash_req_t req,
	output hash_rsp_t rsp
);

	localparam logic [2:0] S_BLK0B = 3'd1;
	localparam logic [2:0] S_BLK1A = 3'd2;
	localparam logic [2:0] S_BLK1B = 3'd3;
	localparam logic [2:0] S_FIN1  = 3'd4;
	localparam logic [2:0] S_FIN2  = 3'd5;
	localparam logic [2:0] S_OUT   = 3'd6;

	logic [2:0]  step_q;
	logic        busy_q;
	logic [31:0] h_q, k_q, b1_q;
	logic        len8_q;
	logic [31:0] fin_a, fin_b, fin2;

	function automatic logic [31:0] rotl15(input logic [31:0] x);
		return {x[16:0], x[31:17]};
	endfunction

	// block mix: h = rotl13(h ^ k) * 5 + e
	function automatic logic [31:0] mix(input logic [31:0] h, input logic [31:0] k);
		logic [31:0] t;
		t = h ^ k;
		t = {t[18:0], t[31:19]};
		return (t << 2) + t + MM_E;
	endfunction

	// finalization operands
	always_comb begin
		fin_a = mix(h_q, k_q) ^ (len8_q ? 32'd8 : 32'd4);
		fin_b = fin_a ^ (fin_a >> 16);
		fin2  = h_q ^ (h_q >> 13);
	end

	assign rsp.done  = busy_q && (step_q == S_OUT);
	assign rsp.value = h_q ^ (h_q >> 16);

	// step sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= S_BLK0B;
		end else if (req.start) begin
			busy_q <= 1'b1;
			step_q <= S_BLK0B;
		end else if (busy_q) begin
			unique case (step_q)
				S_BLK0B: step_q <= len8_q ? S_BLK1A : S_FIN1;
				S_BLK1A: step_q <= S_BLK1B;
				S_BLK1B: step_q <= S_FIN1;
				S_FIN1:  step_q <= S_FIN2;
				S_FIN2:  step_q <= S_OUT;
				default: busy_q <= 1'b0;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			h_q    <= req.seed;
			k_q    <= req.data[31:0] * MM_C1;
			b1_q   <= req.data[63:32];
			len8_q <= req.len8;
		end else if (busy_q) begin
			unique case (step_q)
				S_BLK0B: k_q <= rotl15(k_q) * MM_C2;
				S_BLK1A: begin
					h_q <= mix(h_q, k_q);
					k_q <= b1_q * MM_C1;
				end
				S_BLK1B: k_q <= rotl15(k_q) * MM_C2;
				S_FIN1:  h_q <= fin_b * MM_F1;
				S_FIN2:  h_q <= fin2 * MM_F2;
				default: ;
			endcase
		end
	end

endmodule

>>> rtl/cfe_queue.sv
// small request queue between the hashing front and the table back
module cfe_queue import cfe_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  req_t wdata,
	output logic full,
	input  logic pop,
	output req_t rdata,
	output logic empty
);

	req_t               slot_q [QDEPTH];
	logic [Q_PTR_W-1:0] wp_q, rp_q;
	logic [Q_CNT_W-1:0] cnt_q;

	assign full  = (cnt_q == Q_CNT_W'(QDEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = slot_q[rp_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wp_q <= wp_q + 1'b1;
			if (pop)
				rp_q <= rp_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push)
			slot_q[wp_q] <= wdata;
	end

endmodule

>>> rtl/cfe_front.sv
// front: takes requests, derives fingerprint and both candidate buckets
module cfe_front import cfe_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              enable,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [KEY_W-1:0]  s_tdata,
	input  logic [MODE_W-1:0] s_tuser,
	input  logic [SEED_W-1:0] seed,
	input  logic [BKT_W-1:0]  mask,
	output logic              q_push,
	output req_t              q_data,
	input  logic              q_full
);

	localparam logic [2:0] F_IDLE = 3'd0;
	localparam logic [2:0] F_M1   = 3'd1;
	localparam logic [2:0] F_M2   = 3'd2;
	localparam logic [2:0] F_A1   = 3'd3;
	localparam logic [2:0] F_A2   = 3'd4;
	localparam logic [2:0] F_PUSH = 3'd5;

	logic [2:0]        st_q;
	logic [MODE_W-1:0] mode_q;
	logic [KEY_W-1:0]  key_q;
	logic [FP_W-1:0]   fp_q, fp_new;
	logic [BKT_W-1:0]  h1_q, h2_q, a1_q, m1_q;
	hash_req_t         hreq;
	hash_rsp_t         hrsp;
	logic              accept;

	cfe_murmur u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (hreq),
		.rsp    (hrsp)
	);

	assign s_tready = (st_q == F_IDLE) && enable;
	assign accept   = s_tvalid && s_tready;
	assign q_push   = (st_q == F_PUSH) && !q_full;
	assign q_data   = '{mode: mode_q, fp: fp_q, h1: h1_q, h2: h2_q};

	// fingerprint from both key hashes, zero forced to one
	always_comb begin
		fp_new = FP_W'(salt_mod(m1_q, hrsp.value[BKT_W-1:0], FP_SALT, mask));
		if (fp_new == '0)
			fp_new = FP_W'(1);
	end

	// hash request selection per step
	always_comb begin
		hreq.start = 1'b0;
		hreq.len8  = 1'b1;
		hreq.seed  = seed;
		hreq.data  = key_q;
		unique case (st_q)
			F_IDLE: begin
				hreq.start = accept;
				hreq.data  = s_tdata;
			end
			F_M1: begin
				hreq.start = hrsp.done;
				hreq.seed  = hrsp.value;
			end
			F_M2: begin
				hreq.start = hrsp.done;
				hreq.len8  = 1'b0;
				hreq.data  = {{(KEY_W-FP_W){1'b0}}, fp_new};
			end
			F_A1: begin
				hreq.start = hrsp.done;
				hreq.len8  = 1'b0;
				hreq.seed  = hrsp.value;
				hreq.data  = {{(KEY_W-FP_W){1'b0}}, fp_q};
			end
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= F_IDLE;
		end else begin
			unique case (st_q)
				F_IDLE: if (accept) st_q <= F_M1;
				F_M1:   if (hrsp.done) st_q <= F_M2;
				F_M2:   if (hrsp.done) st_q <= F_A1;
				F_A1:   if (hrsp.done) st_q <= F_A2;
				F_A2:   if (hrsp.done) st_q <= F_PUSH;
				F_PUSH: if (!q_full) st_q <= F_IDLE;
				default: st_q <= F_IDLE;
			endcase
		end
	end

	// request payload
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= s_tuser;
			key_q  <= s_tdata;
		end
		if (st_q == F_M1 && hrsp.done) begin
			m1_q <= hrsp.value[BKT_W-1:0];
			h1_q <= hrsp.value[BKT_W-1:0] & mask;
		end
		if (st_q == F_M2 && hrsp.done)
			fp_q <= fp_new;
		if (st_q == F_A1 && hrsp.done)
			a1_q <= hrsp.value[BKT_W-1:0];
		if (st_q == F_A2 && hrsp.done)
			h2_q <= (h1_q ^ salt_mod(a1_q, hrsp.value[BKT_W-1:0], ALT_SALT, mask)) & mask;
	end

endmodule

>>> rtl/cfe_back.sv
// back: bucket memory, victim slot, eviction loop and result register
module cfe_back import cfe_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	output logic              ready,
	input  logic              q_empty,
	input  req_t              q_head,
	output logic              q_pop,
	input  logic [KICK_W-1:0] max_kicks,
	input  logic [SEED_W-1:0] seed,
	input  logic [BKT_W-1:0]  mask,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [OUT_W-1:0]  m_tdata
);

	localparam logic [3:0] B_CLR   = 4'd0;
	localparam logic [3:0] B_IDLE  = 4'd1;
	localparam logic [3:0] B_R1    = 4'd2;
	localparam logic [3:0] B_R2    = 4'd3;
	localparam logic [3:0] B_KSWAP = 4'd4;
	localparam logic [3:0] B_KA1   = 4'd5;
	localparam logic [3:0] B_KA2   = 4'd6;
	localparam logic [3:0] B_KR1   = 4'd7;
	localparam logic [3:0] B_KR2   = 4'd8;
	localparam logic [3:0] B_DONE  = 4'd9;

	// bucket rows, four nests each
	logic [ROW_W-1:0] mem [BUCKETS];
	logic [ROW_W-1:0] rd_q;
	logic             mem_we, mem_re;
	logic [BKT_W-1:0] mem_wa, mem_ra;
	logic [ROW_W-1:0] mem_wd;

	logic [3:0]        st_q, st_d;
	logic [BKT_W-1:0]  clr_q, clr_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic [FP_W-1:0]   vfp_q, vfp_d;
	logic [BKT_W-1:0]  vb_q, vb_d;
	logic              vv_q, vv_d;
	logic [31:0]       lfsr_q, lfsr_d;
	logic              ov_q, ov_d;
	logic [OUT_W-1:0]  od_q, od_d;

	req_t              cur_q, cur_d;
	logic [ROW_W-1:0]  row1_q, row1_d, rowa_q, rowa_d, rowb_q, rowb_d;
	logic [FP_W-1:0]   kfp_q, kfp_d;
	logic [BKT_W-1:0]  kh_q, kh_d, kh2_q, kh2_d, a1_q, a1_d;
	logic [KICK_W-1:0] depth_q, depth_d;
	logic [STAT_W-1:0] stat_q, stat_d;

	hash_req_t         hreq;
	hash_rsp_t         hrsp;

	logic [NESTS-1:0]  m1v, m2v, f1v, f2v, kfa, kfb;
	logic              in_vic, found;
	logic [31:0]       d1, d2;
	logic [BKT_W-1:0]  krow_h;
	logic [ROW_W-1:0]  krow;
	logic [NEST_W-1:0] kcol;
	logic [FP_W-1:0]   kout;

	function automatic logic [NESTS-1:0] match_vec(input logic [ROW_W-1:0] row,
		input logic [FP_W-1:0] fp);
		logic [NESTS-1:0] v;
		for (int i = 0; i < NESTS; i++)
			v[i] = (row[i*FP_W +: FP_W] == fp);
		return v;
	endfunction

	function automatic logic [NEST_W-1:0] first_idx(input logic [NESTS-1:0] v);
		logic [NEST_W-1:0] idx;
		idx = '0;
		for (int i = NESTS - 1; i >= 0; i--)
			if (v[i])
				idx = NEST_W'(i);
		return idx;
	endfunction

	function automatic logic [ROW_W-1:0] set_nest(input logic [ROW_W-1:0] row,
		input logic [NEST_W-1:0] idx, input logic [FP_W-1:0] val);
		logic [ROW_W-1:0] r;
		r = row;
		r[idx*FP_W +: FP_W] = val;
		return r;
	endfunction

	cfe_murmur u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (hreq),
		.rsp    (hrsp)
	);

	assign ready    = (st_q != B_CLR);
	assign m_tvalid = ov_q;
	assign m_tdata  = od_q;

	// membership and free-nest checks
	always_comb begin
		m1v    = match_vec(row1_q, cur_q.fp);
		m2v    = match_vec(rd_q, cur_q.fp);
		f1v    = match_vec(row1_q, '0);
		f2v    = match_vec(rd_q, '0);
		kfa    = match_vec(rowa_q, '0);
		kfb    = match_vec(rd_q, '0);
		in_vic = vv_q && (vfp_q == cur_q.fp) && ((vb_q == cur_q.h1) || (vb_q == cur_q.h2));
		found  = (|m1v) || (|m2v) || in_vic;
	end

	// eviction pick: two lfsr draws, bucket then nest
	always_comb begin
		d1     = lfsr_next(lfsr_q);
		d2     = lfsr_next(d1);
		krow_h = d1[0] ? kh2_q : kh_q;
		krow   = d1[0] ? rowb_q : rowa_q;
		kcol   = d2[NEST_W-1:0];
		kout   = krow[kcol*FP_W +: FP_W];
	end

	// request sequencing
	always_comb begin
		st_d    = st_q;
		clr_d   = clr_q;
		cnt_d   = cnt_q;
		vfp_d   = vfp_q;
		vb_d    = vb_q;
		vv_d    = vv_q;
		lfsr_d  = lfsr_q;
		ov_d    = ov_q;
		od_d    = od_q;
		cur_d   = cur_q;
		row1_d  = row1_q;
		rowa_d  = rowa_q;
		rowb_d  = rowb_q;
		kfp_d   = kfp_q;
		kh_d    = kh_q;
		kh2_d   = kh2_q;
		a1_d    = a1_q;
		depth_d = depth_q;
		stat_d  = stat_q;
		mem_we  = 1'b0;
		mem_wa  = clr_q;
		mem_wd  = '0;
		mem_re  = 1'b0;
		mem_ra  = q_head.h1;
		q_pop   = 1'b0;
		hreq.start = 1'b0;
		hreq.len8  = 1'b0;
		hreq.seed  = seed;
		hreq.data  = {{(KEY_W-FP_W){1'b0}}, kfp_q};

		if (ov_q && m_tready)
			ov_d = 1'b0;

		unique case (st_q)
			B_CLR: begin
				mem_we = 1'b1;
				clr_d  = clr_q + 1'b1;
				if (clr_q == '1)
					st_d = B_IDLE;
			end
			B_IDLE: begin
				if (!q_empty && !ov_q) begin
					q_pop  = 1'b1;
					cur_d  = q_head;
					mem_re = 1'b1;
					st_d   = B_R1;
				end
			end
			B_R1: begin
				row1_d = rd_q;
				mem_re = 1'b1;
				mem_ra = cur_q.h2;
				st_d   = B_R2;
			end
			B_R2: begin
				st_d = B_DONE;
				priority if (cur_q.mode == MODE_INSERT) begin
					priority if (found) begin
						stat_d = ST_OK;
					end else if (vv_q) begin
						stat_d = ST_FULL;
					end else if (|f1v) begin
						mem_we = 1'b1;
						mem_wa = cur_q.h1;
						mem_wd = set_nest(row1_q, first_idx(f1v), cur_q.fp);
						cnt_d  = cnt_q + 1'b1;
						stat_d = ST_OK;
					end else if (|f2v) begin
						mem_we = 1'b1;
						mem_wa = cur_q.h2;
						mem_wd = set_nest(rd_q, first_idx(f2v), cur_q.fp);
						cnt_d  = cnt_q + 1'b1;
						stat_d = ST_OK;
					end else if (max_kicks == '0) begin
						vfp_d  = cur_q.fp;
						vb_d   = cur_q.h1;
						vv_d   = 1'b1;
						stat_d = ST_FULL;
					end else begin
						rowa_d  = row1_q;
						rowb_d  = rd_q;
						kfp_d   = cur_q.fp;
						kh_d    = cur_q.h1;
						kh2_d   = cur_q.h2;
						depth_d = '0;
						st_d    = B_KSWAP;
					end
				end else if (cur_q.mode == MODE_REMOVE) begin
					priority if (|m1v) begin
						mem_we = 1'b1;
						mem_wa = cur_q.h1;
						mem_wd = set_nest(row1_q, first_idx(m1v), '0);
						if (cnt_q != '0)
							cnt_d = cnt_q - 1'b1;
						stat_d = ST_OK;
					end else if (|m2v) begin
						mem_we = 1'b1;
						mem_wa = cur_q.h2;
						mem_wd = set_nest(rd_q, first_idx(m2v), '0);
						if (cnt_q != '0)
							cnt_d = cnt_q - 1'b1;
						stat_d = ST_OK;
					end else if (in_vic) begin
						vv_d   = 1'b0;
						vfp_d  = '0;
						vb_d   = '0;
						stat_d = ST_OK;
					end else begin
						stat_d = ST_MISS;
					end
				end else begin
					stat_d = found ? ST_OK : ST_MISS;
				end
			end
			B_KSWAP: begin
				mem_we     = 1'b1;
				mem_wa     = krow_h;
				mem_wd     = set_nest(krow, kcol, kfp_q);
				lfsr_d     = d2;
				kfp_d      = kout;
				kh_d       = krow_h;
				depth_d    = depth_q + 1'b1;
				hreq.start = 1'b1;
				hreq.data  = {{(KEY_W-FP_W){1'b0}}, kout};
				st_d       = B_KA1;
			end
			B_KA1: begin
				if (hrsp.done) begin
					a1_d       = hrsp.value[BKT_W-1:0];
					hreq.start = 1'b1;
					hreq.seed  = hrsp.value;
					st_d       = B_KA2;
				end
			end
			B_KA2: begin
				if (hrsp.done) begin
					kh2_d  = (kh_q ^ salt_mod(a1_q, hrsp.value[BKT_W-1:0], ALT_SALT, mask))
						& mask;
					mem_re = 1'b1;
					mem_ra = kh_q;
					st_d   = B_KR1;
				end
			end
			B_KR1: begin
				rowa_d = rd_q;
				mem_re = 1'b1;
				mem_ra = kh2_q;
				st_d   = B_KR2;
			end
			B_KR2: begin
				st_d = B_DONE;
				priority if (|kfa) begin
					mem_we = 1'b1;
					mem_wa = kh_q;
					mem_wd = set_nest(rowa_q, first_idx(kfa), kfp_q);
					cnt_d  = cnt_q + 1'b1;
					stat_d = ST_OK;
				end else if (|kfb) begin
					mem_we = 1'b1;
					mem_wa = kh2_q;
					mem_wd = set_nest(rd_q, first_idx(kfb), kfp_q);
					cnt_d  = cnt_q + 1'b1;
					stat_d = ST_OK;
				end else if (depth_q == max_kicks) begin
					vfp_d  = kfp_q;
					vb_d   = kh_q;
					vv_d   = 1'b1;
					stat_d = ST_FULL;
				end else begin
					rowb_d = rd_q;
					st_d   = B_KSWAP;
				end
			end
			B_DONE: begin
				ov_d = 1'b1;
				od_d = {{(OUT_W-STAT_W-FP_W-CNT_W-1){1'b0}}, vv_q,
					cnt_q + CNT_W'(vv_q), cur_q.fp, stat_q};
				st_d = B_IDLE;
			end
			default: st_d = B_IDLE;
		endcase
	end

	// control and filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= B_CLR;
			clr_q  <= '0;
			cnt_q  <= '0;
			vfp_q  <= '0;
			vb_q   <= '0;
			vv_q   <= 1'b0;
			lfsr_q <= 32'd1;
			ov_q   <= 1'b0;
		end else begin
			st_q   <= st_d;
			clr_q  <= clr_d;
			cnt_q  <= cnt_d;
			vfp_q  <= vfp_d;
			vb_q   <= vb_d;
			vv_q   <= vv_d;
			lfsr_q <= lfsr_d;
			ov_q   <= ov_d;
		end
	end

	// working payload
	always_ff @(posedge clk) begin
		od_q    <= od_d;
		cur_q   <= cur_d;
		row1_q  <= row1_d;
		rowa_q  <= rowa_d;
		rowb_q  <= rowb_d;
		kfp_q   <= kfp_d;
		kh_q    <= kh_d;
		kh2_q   <= kh2_d;
		a1_q    <= a1_d;
		depth_q <= depth_d;
		stat_q  <= stat_d;
	end

	// bucket memory, registered read
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= mem_wd;
		if (mem_re)
			rd_q <= mem[mem_ra];
	end

endmodule

>>> rtl/cfe_checker.sv
// port-level checks on the result stream, bound to the top level
`include "cuckoo_filter_engine_unit_assert.svh"

module cfe_checker import cfe_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata
);

	// a stalled result holds
	`CFE_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped or changed while stalled")

	// status is one of ok, not found, full
	`CFE_IMPLIES(a_status_code, m_tvalid, m_tdata[1:0] != 2'd3, "undefined status code")

	// fingerprint is never zero
	`CFE_IMPLIES(a_fp_nonzero, m_tvalid, m_tdata[17:2] != 16'd0, "zero fingerprint reported")

	// a held victim is counted
	`CFE_IMPLIES(a_victim_count, m_tvalid && m_tdata[33], m_tdata[32:18] != 15'd0, "victim held but total is zero")

endmodule

bind cuckoo_filter_engine_unit cfe_checker u_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

>>> tb/sv/cuckoo_filter_engine_unit_test.sv
// cuckoo filter testbench: scoreboard with its own filter copy, directed and random traffic
module cuckoo_filter_engine_unit_test;
	import cfe_pkg::*;

	typedef struct {
		bit [STAT_W-1:0] status;
		bit [FP_W-1:0]   fp;
		bit [CNT_W-1:0]  total;
		bit              victim;
	} filter_answer_t;

	// filter copy plus the queue of answers still owed by the engine
	class filter_scoreboard;
		bit [FP_W-1:0]  nests[BUCKETS*NESTS];
		int unsigned    stored;
		bit [FP_W-1:0]  victim_fp;
		int unsigned    victim_bkt;
		bit             victim_on;
		bit [31:0]      kick_state;
		bit [LOG_W-1:0] log_size;
		int unsigned    kick_limit;
		bit [31:0]      seed;
		filter_answer_t expected_answers[$];
		int             errors;
		int             full_seen;
		int             answers_seen;

		function new();
			foreach (nests[i]) nests[i] = '0;
			stored = 0;
			victim_fp = '0;
			victim_bkt = 0;
			victim_on = 0;
			kick_state = 32'd1;
			log_size = 4'd12;
			kick_limit = 100;
			seed = '0;
			errors = 0;
			full_seen = 0;
			answers_seen = 0;
		endfunction

		function void set_reg(bit [CFG_IDX_W-1:0] idx, bit [CFG_W-1:0] val);
			if (idx == REG_LOG)
				log_size = val[LOG_W-1:0];
			else if (idx == REG_KICKS)
				kick_limit = val[KICK_W-1:0];
			else if (idx == REG_SEED)
				seed = val;
		endfunction

		// murmur3 x86_32 over nwords little-endian 32-bit words
		function bit [31:0] murmur(bit [63:0] d, int nwords, bit [31:0] s);
			bit [31:0] h, k;
			h = s;
			for (int i = 0; i < nwords; i++) begin
				k = d[32*i +: 32];
				k = k * MM_C1;
				k = {k[16:0], k[31:17]};
				k = k * MM_C2;
				h = h ^ k;
				h = {h[18:0], h[31:19]};
				h = h * 32'd5 + MM_E;
			end
			h = h ^ (nwords * 4);
			h = h ^ (h >> 16);
			h = h * MM_F1;
			h = h ^ (h >> 13);
			h = h * MM_F2;
			h = h ^ (h >> 16);
			return h;
		endfunction

		function int unsigned bucket_span();
			return (log_size >= 4'd12) ? BUCKETS : (1 << log_size);
		endfunction

		function int unsigned salted(bit [63:0] d, int nwords, bit [31:0] n);
			bit [31:0] m1, m2, s;
			m1 = murmur(d, nwords, seed);
			m2 = murmur(d, nwords, m1);
			s = m1 + n * m2;
			return s & (bucket_span() - 1);
		endfunction

		function int unsigned other_bucket(bit [FP_W-1:0] f, int unsigned h);
			return (h ^ salted({48'b0, f}, 1, 32'd900)) & (bucket_span() - 1);
		endfunction

		function bit [31:0] kick_draw();
			bit lsb;
			lsb = kick_state[0];
			kick_state = kick_state >> 1;
			if (lsb)
				kick_state = kick_state ^ 32'h80200003;
			return kick_state;
		endfunction

		function bit holds(int unsigned h, bit [FP_W-1:0] f);
			for (int i = 0; i < NESTS; i++)
				if (nests[h*NESTS+i] == f)
					return 1;
			return 0;
		endfunction

		function bit fill_free(int unsigned h, bit [FP_W-1:0] f);
			for (int i = 0; i < NESTS; i++)
				if (nests[h*NESTS+i] == '0) begin
					nests[h*NESTS+i] = f;
					stored++;
					return 1;
				end
			return 0;
		endfunction

		function bit drop_one(int unsigned h, bit [FP_W-1:0] f);
			for (int i = 0; i < NESTS; i++)
				if (nests[h*NESTS+i] == f) begin
					nests[h*NESTS+i] = '0;
					if (stored > 0)
						stored--;
					return 1;
				end
			return 0;
		endfunction

		// free nest first, then random evictions until the kick limit
		function bit [STAT_W-1:0] insert_fp(bit [FP_W-1:0] f, int unsigned h);
			int unsigned depth, h2, row, col;
			bit [FP_W-1:0] out;
			depth = 0;
			forever begin
				h2 = other_bucket(f, h);
				if (fill_free(h, f))
					return ST_OK;
				if (fill_free(h2, f))
					return ST_OK;
				if (depth == kick_limit) begin
					victim_fp = f;
					victim_bkt = h;
					victim_on = 1;
					return ST_FULL;
				end
				row = (kick_draw() & 1) == 0 ? h : h2;
				col = kick_draw() % NESTS;
				out = nests[row*NESTS+col];
				nests[row*NESTS+col] = f;
				f = out;
				h = row;
				depth++;
			end
		endfunction

		function void note_request(bit [MODE_W-1:0] mode, bit [KEY_W-1:0] key);
			filter_answer_t a;
			bit [31:0] raw;
			bit [FP_W-1:0] f;
			int unsigned h1, h2;
			bit in_victim, found;
			raw = salted(key, 2, 32'd1000);
			f = raw[FP_W-1:0];
			if (f == '0)
				f = 1;
			h1 = salted(key, 2, 32'd0);
			h2 = other_bucket(f, h1);
			in_victim = victim_on && victim_fp == f && (victim_bkt == h1 || victim_bkt == h2);
			found = holds(h1, f) || holds(h2, f) || in_victim;
			if (mode == MODE_INSERT) begin
				if (found)
					a.status = ST_OK;
				else if (victim_on)
					a.status = ST_FULL;
				else
					a.status = insert_fp(f, h1);
			end else if (mode == MODE_REMOVE) begin
				if (drop_one(h1, f))
					a.status = ST_OK;
				else if (drop_one(h2, f))
					a.status = ST_OK;
				else if (in_victim) begin
					victim_on = 0;
					victim_fp = '0;
					victim_bkt = 0;
					a.status = ST_OK;
				end else
					a.status = ST_MISS;
			end else
				a.status = found ? ST_OK : ST_MISS;
			a.fp = f;
			a.total = CNT_W'(stored + victim_on);
			a.victim = victim_on;
			expected_answers.push_back(a);
		endfunction

		function void check_result(bit [OUT_W-1:0] d);
			filter_answer_t a;
			answers_seen++;
			if (expected_answers.size() == 0) begin
				$error("result with no request pending: %h", d);
				errors++;
				return;
			end
			a = expected_answers.pop_front();
			if (a.status == ST_FULL)
				full_seen++;
			if (d[1:0] != a.status) begin
				$error("status: expected %0d, got %0d", a.status, d[1:0]);
				errors++;
			end
			if (d[17:2] != a.fp) begin
				$error("fingerprint: expected %h, got %h", a.fp, d[17:2]);
				errors++;
			end
			if (d[32:18] != a.total) begin
				$error("stored_total: expected %0d, got %0d", a.total, d[32:18]);
				errors++;
			end
			if (d[33] != a.victim) begin
				$error("victim_held: expected %0d, got %0d", a.victim, d[33]);
				errors++;
			end
		endfunction
	endclass

	logic                 clk = 0;
	logic                 arst_n = 0;
	logic                 s_tvalid = 0;
	logic                 s_tready;
	logic [KEY_W-1:0]     s_tdata = '0;
	logic [MODE_W-1:0]    s_tuser = '0;
	logic                 m_tvalid;
	logic                 m_tready = 0;
	logic [OUT_W-1:0]     m_tdata;
	logic                 cfg_we = 0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_wdata = '0;

	filter_scoreboard board = new();
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int requests_sent = 0;
	int settings_used = 1;
	bit [KEY_W-1:0] key_pool[$];

	cuckoo_filter_engine_unit i_dut (.*);

	always #1 clk = ~clk;

	// receive side: random stalls, check each accepted result
	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			board.check_result(m_tdata);
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// watchdog, sized for every insert running the longest eviction chain
	initial begin
		#200000000;
		$display("TEST FAILED");
		$finish;
	end

	// one request, held until accepted
	task send_request(input bit [MODE_W-1:0] mode, input bit [KEY_W-1:0] key);
		if ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct)
				@(posedge clk);
		end
		s_tvalid <= 1;
		s_tuser <= mode;
		s_tdata <= key;
		do @(posedge clk); while (!s_tready);
		board.note_request(mode, key);
		requests_sent++;
	endtask

	// wait for every owed result, then let the engine settle
	task drain;
		s_tvalid <= 0;
		while (board.expected_answers.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	// write all three registers, one per cycle
	task write_regs(input bit [LOG_W-1:0] lg, input bit [KICK_W-1:0] kicks,
		input bit [31:0] sd);
		cfg_we <= 1;
		cfg_index <= REG_LOG;
		cfg_wdata <= CFG_W'(lg);
		@(posedge clk);
		board.set_reg(REG_LOG, CFG_W'(lg));
		cfg_index <= REG_KICKS;
		cfg_wdata <= CFG_W'(kicks);
		@(posedge clk);
		board.set_reg(REG_KICKS, CFG_W'(kicks));
		cfg_index <= REG_SEED;
		cfg_wdata <= sd;
		@(posedge clk);
		board.set_reg(REG_SEED, sd);
		cfg_we <= 0;
		@(posedge clk);
		settings_used++;
	endtask

	function bit [KEY_W-1:0] pick_key(int reuse_pct);
		if (key_pool.size() != 0 && $urandom_range(99) < reuse_pct)
			return key_pool[$urandom_range(key_pool.size() - 1)];
		return {$urandom, $urandom};
	endfunction

	// inserts that grow the filter, lookups and removes mostly of known keys, and the unused mode
	task random_traffic(input int count);
		int pick;
		bit [KEY_W-1:0] k;
		repeat (count) begin
			pick = $urandom_range(99);
			if (pick < 45) begin
				k = pick_key(30);
				send_request(MODE_INSERT, k);
				key_pool.push_back(k);
				if (key_pool.size() > 64)
					void'(key_pool.pop_front());
			end else if (pick < 75)
				send_request(MODE_LOOKUP, pick_key(70));
			else if (pick < 95)
				send_request(MODE_REMOVE, pick_key(70));
			else
				send_request(2'd3, pick_key(50));
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: key extremes, every mode, duplicates, misses
		send_request(MODE_LOOKUP, '0);
		send_request(MODE_INSERT, '0);
		send_request(MODE_INSERT, '0);
		send_request(MODE_LOOKUP, '0);
		send_request(MODE_INSERT, '1);
		send_request(2'd3, '1);
		send_request(MODE_REMOVE, '1);
		send_request(MODE_REMOVE, '1);
		send_request(MODE_LOOKUP, '1);
		send_request(MODE_INSERT, 64'h8000_0000_0000_0001);
		send_request(MODE_INSERT, 64'h5555_5555_5555_5555);
		send_request(MODE_INSERT, 64'haaaa_aaaa_aaaa_aaaa);
		send_request(MODE_REMOVE, 64'h1234_5678_9abc_def0);
		send_request(MODE_LOOKUP, 64'h5555_5555_5555_5555);
		send_request(MODE_REMOVE, '0);
		send_request(2'd3, '0);
		drain();

		// tiny table, no kicks: every key maps to fingerprint one in the single bucket
		write_regs(4'd0, 10'd0, 32'd0);
		send_request(MODE_INSERT, 64'h1);
		send_request(MODE_INSERT, 64'h2);
		send_request(MODE_INSERT, 64'h3);
		send_request(MODE_INSERT, 64'h4);
		send_request(MODE_INSERT, 64'h5);
		send_request(MODE_INSERT, 64'h6);
		send_request(MODE_LOOKUP, 64'h6);
		send_request(MODE_REMOVE, 64'h6);
		random_traffic(230);
		drain();

		send_idle_pct = 79;
		write_regs(4'd2, 10'd5, $urandom);
		random_traffic(250);
		drain();

		send_idle_pct = 0;
		recv_stall_pct = 79;
		write_regs(4'd15, 10'd1023, 32'hffff_ffff);
		random_traffic(250);
		drain();

		send_idle_pct = 31;
		recv_stall_pct = 31;
		write_regs(4'd3, 10'd1023, $urandom);
		random_traffic(150);
		drain();

		send_idle_pct = 0;
		recv_stall_pct = 0;
		write_regs(4'd6, 10'd50, $urandom);
		random_traffic(250);
		drain();

		send_idle_pct = 31;
		recv_stall_pct = 31;
		write_regs(4'd12, 10'd100, 32'd0);
		random_traffic(350);
		drain();

		$display("covered %0d requests under %0d register settings", requests_sent,
			settings_used);
		$display("%0d results checked, %0d table-full answers", board.answers_seen,
			board.full_seen);
		if (board.errors == 0 && board.expected_answers.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
